// ===== rtl/c8_pkg.sv =====
package c8_pkg;

	localparam int MEM_BYTES       = 4096;
	localparam int AW              = 12;
	localparam int SCREEN_W        = 64;
	localparam int SCREEN_H        = 32;
	localparam int ROW_AW          = 5;
	localparam int STACK_DEPTH_DEF = 16;
	localparam int FONT_BYTES      = 80;

	localparam logic [AW-1:0] PC_RESET = 12'h200;

	// request codes
	localparam logic [1:0] RQ_EXEC  = 2'd0;
	localparam logic [1:0] RQ_WRITE = 2'd1;
	localparam logic [1:0] RQ_ROW   = 2'd2;
	localparam logic [1:0] RQ_NOP   = 2'd3;

	// major opcodes
	localparam logic [3:0] OP_SYS     = 4'h0;
	localparam logic [3:0] OP_JUMP    = 4'h1;
	localparam logic [3:0] OP_CALL    = 4'h2;
	localparam logic [3:0] OP_SKIP_EQ = 4'h3;
	localparam logic [3:0] OP_SKIP_NE = 4'h4;
	localparam logic [3:0] OP_SKIP_RE = 4'h5;
	localparam logic [3:0] OP_SET     = 4'h6;
	localparam logic [3:0] OP_ADD     = 4'h7;
	localparam logic [3:0] OP_ALU     = 4'h8;
	localparam logic [3:0] OP_SKIP_RN = 4'h9;
	localparam logic [3:0] OP_INDEX   = 4'hA;
	localparam logic [3:0] OP_JUMP_V0 = 4'hB;
	localparam logic [3:0] OP_RAND    = 4'hC;
	localparam logic [3:0] OP_DRAW    = 4'hD;
	localparam logic [3:0] OP_KEY     = 4'hE;
	localparam logic [3:0] OP_MISC    = 4'hF;

	localparam logic [15:0] INS_CLS = 16'h00E0;
	localparam logic [15:0] INS_RET = 16'h00EE;

	// ALU sub-codes
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// miscellaneous and key sub-codes
	localparam logic [7:0] FN_DELAY_RD  = 8'h07;
	localparam logic [7:0] FN_KEY_WAIT  = 8'h0A;
	localparam logic [7:0] FN_DELAY_WR  = 8'h15;
	localparam logic [7:0] FN_SOUND_WR  = 8'h18;
	localparam logic [7:0] FN_INDEX_ADD = 8'h1E;
	localparam logic [7:0] FN_GLYPH     = 8'h29;
	localparam logic [7:0] FN_BCD       = 8'h33;
	localparam logic [7:0] FN_STORE     = 8'h55;
	localparam logic [7:0] FN_LOAD      = 8'h65;
	localparam logic [7:0] FN_SKIP_KEY  = 8'h9E;
	localparam logic [7:0] FN_SKIP_NKEY = 8'hA1;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_MEM_WRITE,
		CMD_ROW_READ,
		CMD_FETCH_HI,
		CMD_FETCH_LO,
		CMD_DECODE,
		CMD_EXEC,
		CMD_FLAG,
		CMD_DRAW_RD,
		CMD_DRAW_WR,
		CMD_BCD,
		CMD_STORE_RD,
		CMD_STORE_WR,
		CMD_LOAD_RD,
		CMD_LOAD_WR,
		CMD_FINISH,
		CMD_RESULT
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_FETCH_LO,
		ST_DECODE,
		ST_EXEC,
		ST_FLAG,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_BCD,
		ST_STORE_RD,
		ST_STORE_WR,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_FINISH,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic       clear_last;
		logic [1:0] req_cmd;
		logic [3:0] op;
		logic [7:0] nn;
		logic       n_zero;
		logic       needs_flag;
		logic       loop_last;
		logic       out_free;
	} status_t;

	function automatic logic [7:0] font_byte(input logic [6:0] a);
		logic [7:0] b;
		case (a)
			7'd0: b = 8'hF0; 7'd1: b = 8'h90; 7'd2: b = 8'h90; 7'd3: b = 8'h90;
			7'd4: b = 8'hF0; 7'd5: b = 8'h20; 7'd6: b = 8'h60; 7'd7: b = 8'h20;
			7'd8: b = 8'h20; 7'd9: b = 8'h70; 7'd10: b = 8'hF0; 7'd11: b = 8'h10;
			7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
			7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
			7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
			7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
			7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
			7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
			7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
			7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
			7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
			7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
			7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
			7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
			7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
			7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
			7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
			7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
			7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// hundreds, tens, ones of a byte; tens by reciprocal multiply (valid below 100)
	function automatic logic [11:0] bcd_digits(input logic [7:0] v);
		logic [3:0]  h;
		logic [3:0]  t;
		logic [3:0]  o;
		logic [7:0]  r;
		logic [14:0] p;
		if (v >= 8'd200) begin
			h = 4'd2;
			r = v - 8'd200;
		end else if (v >= 8'd100) begin
			h = 4'd1;
			r = v - 8'd100;
		end else begin
			h = 4'd0;
			r = v;
		end
		p = 15'(r) * 15'd205;
		t = p[14:11];
		o = 4'(r - 8'(t) * 8'd10);
		return {h, t, o};
	endfunction

	function automatic logic [3:0] highest_key(input logic [15:0] k);
		logic [3:0] h;
		h = 4'd0;
		for (int j = 0; j < 16; j++) begin
			if (k[j]) h = 4'(j);
		end
		return h;
	endfunction

endpackage

// ===== rtl/c8_ctrl.sv =====
module c8_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  c8_pkg::status_t status,
	output c8_pkg::cmd_t    cmd,
	output logic            req_stall
);
	import c8_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		cmd       = CMD_NONE;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd = CMD_CLEAR;
				if (status.clear_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd      = CMD_ACCEPT;
					state_nx = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.req_cmd)
					RQ_EXEC: begin
						cmd      = CMD_FETCH_HI;
						state_nx = ST_FETCH_LO;
					end
					RQ_WRITE: begin
						cmd      = CMD_MEM_WRITE;
						state_nx = ST_RESULT;
					end
					RQ_ROW: begin
						cmd      = CMD_ROW_READ;
						state_nx = ST_RESULT;
					end
					default: state_nx = ST_RESULT;
				endcase
			end
			ST_FETCH_LO: begin
				cmd      = CMD_FETCH_LO;
				state_nx = ST_DECODE;
			end
			ST_DECODE: begin
				cmd      = CMD_DECODE;
				state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				cmd      = CMD_EXEC;
				state_nx = ST_FINISH;
				if (status.op == OP_DRAW) begin
					state_nx = status.n_zero ? ST_FLAG : ST_DRAW_RD;
				end else if (status.op == OP_MISC && status.nn == FN_BCD) begin
					state_nx = ST_BCD;
				end else if (status.op == OP_MISC && status.nn == FN_STORE) begin
					state_nx = ST_STORE_RD;
				end else if (status.op == OP_MISC && status.nn == FN_LOAD) begin
					state_nx = ST_LOAD_RD;
				end else if (status.needs_flag) begin
					state_nx = ST_FLAG;
				end
			end
			ST_FLAG: begin
				cmd      = CMD_FLAG;
				state_nx = ST_FINISH;
			end
			ST_DRAW_RD: begin
				cmd      = CMD_DRAW_RD;
				state_nx = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				cmd      = CMD_DRAW_WR;
				state_nx = status.loop_last ? ST_FLAG : ST_DRAW_RD;
			end
			ST_BCD: begin
				cmd = CMD_BCD;
				if (status.loop_last) state_nx = ST_FINISH;
			end
			ST_STORE_RD: begin
				cmd      = CMD_STORE_RD;
				state_nx = ST_STORE_WR;
			end
			ST_STORE_WR: begin
				cmd      = CMD_STORE_WR;
				state_nx = status.loop_last ? ST_FINISH : ST_STORE_RD;
			end
			ST_LOAD_RD: begin
				cmd      = CMD_LOAD_RD;
				state_nx = ST_LOAD_WR;
			end
			ST_LOAD_WR: begin
				cmd      = CMD_LOAD_WR;
				state_nx = status.loop_last ? ST_FINISH : ST_LOAD_RD;
			end
			ST_FINISH: begin
				cmd      = CMD_FINISH;
				state_nx = ST_RESULT;
			end
			ST_RESULT: begin
				cmd = CMD_RESULT;
				if (status.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/c8_datapath.sv =====
module c8_datapath #(
	parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  c8_pkg::cmd_t    cmd,
	output c8_pkg::status_t status,
	input  logic            cfg_write_en,
	input  logic            cfg_write_data,
	input  logic [1:0]      command,
	input  logic [11:0]     address,
	input  logic [7:0]      write_data,
	input  logic [15:0]     key_mask,
	input  logic [7:0]      random_byte,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic [11:0]     program_counter,
	output logic            display_changed,
	output logic            sound_active,
	output logic            waiting_for_key,
	output logic [63:0]     row_pixels
);
	import c8_pkg::*;

	localparam int SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// latched request
	logic [1:0]    rq_cmd_q;
	logic [AW-1:0] rq_addr_q;
	logic [7:0]    rq_data_q;
	logic [15:0]   keys_q;
	logic [7:0]    rnd_q;

	// architectural state
	logic [AW-1:0]  pc_q;
	logic [AW-1:0]  pc_nx_q;
	logic [15:0]    i_q;
	logic [SpW-1:0] sp_q;
	logic [7:0]     dt_q;
	logic [7:0]     st_q;
	logic           mode_q;
	logic [AW-1:0]  stk_q [STACK_DEPTH];

	// sequencing
	logic [AW-1:0]     clr_q;
	logic [7:0]        hi_q;
	logic [15:0]       ins_q;
	logic [3:0]        cnt_q;
	logic              hit_q;
	logic              flag_q;
	logic              changed_q;
	logic              wait_q;
	logic [ROW_AW-1:0] row_q;

	// main memory
	logic [7:0]    mem_q [MEM_BYTES];
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rd_q;

	// register file
	logic [7:0]  rf_q [16];
	logic [15:0] rf_vld_q;
	logic        rf_re;
	logic [3:0]  rf_ra;
	logic [3:0]  rf_rb;
	logic [7:0]  va_q;
	logic [7:0]  vb_q;
	logic        rf_we;
	logic [3:0]  rf_wa;
	logic [7:0]  rf_wd;

	// frame store
	logic [SCREEN_W-1:0] fr_q [SCREEN_H];
	logic [SCREEN_H-1:0] fr_vld_q;
	logic                fr_re;
	logic                fr_we;
	logic                fr_clear;
	logic [ROW_AW-1:0]   fr_addr;
	logic [SCREEN_W-1:0] fr_wd;
	logic [SCREEN_W-1:0] fr_rd_q;

	// output register
	logic                rsp_valid_q;
	logic [AW-1:0]       out_pc_q;
	logic                out_changed_q;
	logic                out_sound_q;
	logic                out_wait_q;
	logic [SCREEN_W-1:0] out_row_q;

	logic [3:0]     op;
	logic [3:0]     fx;
	logic [3:0]     fy;
	logic [3:0]     fn;
	logic [7:0]     nn;
	logic [AW-1:0]  nnn;
	logic [15:0]    ins_nx;
	logic [AW-1:0]  pc_inc;
	logic [AW-1:0]  pc_exec;
	logic [SpW-1:0] sp_inc;
	logic [SpW-1:0] sp_dec;
	logic [AW-1:0]  i_off;
	logic [8:0]     sum9;
	logic [7:0]     shift_src;
	logic           flag_exec;
	logic           key_hit;
	logic [11:0]    digits;
	logic [7:0]     digit;
	logic [127:0]   rot;
	logic [63:0]    mask;
	logic           out_free;
	logic           is_move;

	assign op      = ins_q[15:12];
	assign fx      = ins_q[11:8];
	assign fy      = ins_q[7:4];
	assign fn      = ins_q[3:0];
	assign nn      = ins_q[7:0];
	assign nnn     = ins_q[11:0];
	assign ins_nx  = {hi_q, mem_rd_q};
	assign pc_inc  = pc_q + 12'd2;
	assign sp_inc  = (sp_q == SpW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec  = (sp_q == '0) ? SpW'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign i_off   = i_q[AW-1:0] + AW'(cnt_q);
	assign sum9    = {1'b0, va_q} + {1'b0, vb_q};
	assign shift_src = mode_q ? va_q : vb_q;
	assign key_hit = keys_q[va_q[3:0]];
	assign digits  = bcd_digits(va_q);
	assign rot     = {mem_rd_q, 56'd0, mem_rd_q, 56'd0} >> va_q[5:0];
	assign mask    = rot[63:0];
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign is_move = (op == OP_MISC) && (nn == FN_STORE || nn == FN_LOAD);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    digit = {4'd0, digits[11:8]};
			2'd1:    digit = {4'd0, digits[7:4]};
			default: digit = {4'd0, digits[3:0]};
		endcase
	end

	// status towards the controller
	always_comb begin
		status.clear_last = (clr_q == AW'(MEM_BYTES - 1));
		status.req_cmd    = rq_cmd_q;
		status.op         = op;
		status.nn         = nn;
		status.n_zero     = (fn == 4'd0);
		status.needs_flag = (op == OP_ALU) && (fn == ALU_ADD || fn == ALU_SUB ||
			fn == ALU_SHR || fn == ALU_RSB || fn == ALU_SHL);
		status.out_free   = out_free;
		if (op == OP_DRAW) begin
			status.loop_last = (cnt_q == fn - 4'd1);
		end else if (op == OP_MISC && nn == FN_BCD) begin
			status.loop_last = (cnt_q == 4'd2);
		end else begin
			status.loop_last = (cnt_q == fx);
		end
	end

	// command decode: memory, register-file and frame-store controls; execute: next PC, register write, flag
	always_comb begin
		pc_exec   = pc_inc;
		flag_exec = 1'b0;
		rf_we     = 1'b0;
		rf_wa     = fx;
		rf_wd     = 8'd0;
		rf_re     = 1'b0;
		rf_ra     = fx;
		rf_rb     = fy;
		mem_we    = 1'b0;
		mem_addr  = i_off;
		mem_wdata = 8'd0;
		fr_re     = 1'b0;
		fr_we     = 1'b0;
		fr_clear  = 1'b0;
		fr_addr   = row_q;
		fr_wd     = fr_rd_q ^ mask;
		case (cmd)
			CMD_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = (clr_q < AW'(FONT_BYTES)) ? font_byte(clr_q[6:0]) : 8'd0;
			end
			CMD_MEM_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = rq_addr_q;
				mem_wdata = rq_data_q;
			end
			CMD_ROW_READ: begin
				fr_re   = 1'b1;
				fr_addr = rq_addr_q[ROW_AW-1:0];
			end
			CMD_FETCH_HI: mem_addr = pc_q;
			CMD_FETCH_LO: mem_addr = pc_q + 12'd1;
			CMD_DECODE: begin
				rf_re = 1'b1;
				rf_ra = (ins_nx[15:12] == OP_JUMP_V0) ? 4'd0 : ins_nx[11:8];
				rf_rb = ins_nx[7:4];
			end
			CMD_EXEC: begin
				case (op)
					OP_SYS: begin
						if (ins_q == INS_CLS) fr_clear = 1'b1;
						if (ins_q == INS_RET) pc_exec = stk_q[sp_dec];
					end
					OP_JUMP, OP_CALL: pc_exec = nnn;
					OP_SKIP_EQ: if (va_q == nn) pc_exec = pc_q + 12'd4;
					OP_SKIP_NE: if (va_q != nn) pc_exec = pc_q + 12'd4;
					OP_SKIP_RE: if (va_q == vb_q) pc_exec = pc_q + 12'd4;
					OP_SKIP_RN: if (va_q != vb_q) pc_exec = pc_q + 12'd4;
					OP_SET: begin
						rf_we = 1'b1;
						rf_wd = nn;
					end
					OP_ADD: begin
						rf_we = 1'b1;
						rf_wd = va_q + nn;
					end
					OP_ALU: begin
						rf_we = 1'b1;
						case (fn)
							ALU_MOV: rf_wd = vb_q;
							ALU_OR:  rf_wd = va_q | vb_q;
							ALU_AND: rf_wd = va_q & vb_q;
							ALU_XOR: rf_wd = va_q ^ vb_q;
							ALU_ADD: begin
								rf_wd     = sum9[7:0];
								flag_exec = sum9[8];
							end
							ALU_SUB: begin
								rf_wd     = va_q - vb_q;
								flag_exec = (va_q >= vb_q);
							end
							ALU_SHR: begin
								rf_wd     = {1'b0, shift_src[7:1]};
								flag_exec = shift_src[0];
							end
							ALU_RSB: begin
								rf_wd     = vb_q - va_q;
								flag_exec = (vb_q >= va_q);
							end
							ALU_SHL: begin
								rf_wd     = {shift_src[6:0], 1'b0};
								flag_exec = shift_src[7];
							end
							default: rf_we = 1'b0;
						endcase
					end
					OP_JUMP_V0: pc_exec = AW'(va_q) + nnn;
					OP_RAND: begin
						rf_we = 1'b1;
						rf_wd = rnd_q & nn;
					end
					OP_KEY: begin
						if (nn == FN_SKIP_KEY && key_hit) pc_exec = pc_q + 12'd4;
						if (nn == FN_SKIP_NKEY && !key_hit) pc_exec = pc_q + 12'd4;
					end
					OP_MISC: begin
						if (nn == FN_DELAY_RD) begin
							rf_we = 1'b1;
							rf_wd = dt_q;
						end else if (nn == FN_KEY_WAIT) begin
							if (keys_q == 16'd0) begin
								pc_exec = pc_q;
							end else begin
								rf_we = 1'b1;
								rf_wd = {4'd0, highest_key(keys_q)};
							end
						end
					end
					default: pc_exec = pc_inc;
				endcase
			end
			CMD_FLAG: begin
				rf_we = 1'b1;
				rf_wa = 4'hF;
				rf_wd = {7'd0, (op == OP_DRAW) ? hit_q : flag_q};
			end
			CMD_DRAW_RD: begin
				fr_re   = 1'b1;
				fr_addr = vb_q[ROW_AW-1:0] + ROW_AW'(cnt_q);
			end
			CMD_DRAW_WR: fr_we = 1'b1;
			CMD_BCD: begin
				mem_we    = 1'b1;
				mem_wdata = digit;
			end
			CMD_STORE_RD: begin
				rf_re = 1'b1;
				rf_ra = cnt_q;
			end
			CMD_STORE_WR: begin
				mem_we    = 1'b1;
				mem_wdata = va_q;
			end
			CMD_LOAD_WR: begin
				rf_we = 1'b1;
				rf_wa = cnt_q;
				rf_wd = mem_rd_q;
			end
			default: mem_addr = i_off;
		endcase
	end

	// main memory: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wdata;
		mem_rd_q <= mem_q[mem_addr];
	end

	// register file: one write, two registered reads
	always_ff @(posedge clk) begin
		if (rf_we) rf_q[rf_wa] <= rf_wd;
		if (rf_re) begin
			va_q <= rf_vld_q[rf_ra] ? rf_q[rf_ra] : 8'd0;
			vb_q <= rf_vld_q[rf_rb] ? rf_q[rf_rb] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we) begin
			rf_vld_q[rf_wa] <= 1'b1;
		end
	end

	// frame store: rows read as blank until drawn
	always_ff @(posedge clk) begin
		if (fr_we) fr_q[fr_addr] <= fr_wd;
		if (fr_re) fr_rd_q <= fr_vld_q[fr_addr] ? fr_q[fr_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_vld_q <= '0;
		end else if (fr_clear) begin
			fr_vld_q <= '0;
		end else if (fr_we) begin
			fr_vld_q[fr_addr] <= 1'b1;
		end
	end

	// return stack
	always_ff @(posedge clk) begin
		if (cmd == CMD_EXEC && op == OP_CALL) stk_q[sp_q] <= pc_inc;
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				rq_addr_q <= address;
				rq_data_q <= write_data;
				keys_q    <= key_mask;
				rnd_q     <= random_byte;
			end
			CMD_FETCH_LO: hi_q <= mem_rd_q;
			CMD_DECODE:   ins_q <= ins_nx;
			CMD_EXEC: begin
				pc_nx_q <= pc_exec;
				flag_q  <= flag_exec;
			end
			CMD_DRAW_RD: row_q <= fr_addr;
			default: row_q <= row_q;
		endcase
	end

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_cmd_q  <= RQ_NOP;
			pc_q      <= PC_RESET;
			i_q       <= '0;
			sp_q      <= '0;
			dt_q      <= '0;
			st_q      <= '0;
			mode_q    <= 1'b0;
			clr_q     <= '0;
			cnt_q     <= '0;
			hit_q     <= 1'b0;
			changed_q <= 1'b0;
			wait_q    <= 1'b0;
		end else begin
			if (cfg_write_en) mode_q <= cfg_write_data;
			case (cmd)
				CMD_CLEAR: clr_q <= clr_q + 1'b1;
				CMD_ACCEPT: begin
					rq_cmd_q  <= command;
					changed_q <= 1'b0;
					wait_q    <= 1'b0;
				end
				CMD_EXEC: begin
					cnt_q     <= '0;
					hit_q     <= 1'b0;
					changed_q <= (ins_q == INS_CLS) || (op == OP_DRAW);
					wait_q    <= (op == OP_MISC) && (nn == FN_KEY_WAIT) && (keys_q == 16'd0);
					if (op == OP_CALL) sp_q <= sp_inc;
					if (ins_q == INS_RET) sp_q <= sp_dec;
					if (op == OP_INDEX) i_q <= {4'd0, nnn};
					if (op == OP_MISC) begin
						if (nn == FN_DELAY_WR) dt_q <= va_q;
						if (nn == FN_SOUND_WR) st_q <= va_q;
						if (nn == FN_INDEX_ADD) i_q <= i_q + {8'd0, va_q};
						if (nn == FN_GLYPH) i_q <= {6'd0, va_q, 2'd0} + {8'd0, va_q};
					end
				end
				CMD_DRAW_WR: begin
					hit_q <= hit_q | (|(fr_rd_q & mask));
					cnt_q <= cnt_q + 1'b1;
				end
				CMD_BCD, CMD_STORE_WR, CMD_LOAD_WR: cnt_q <= cnt_q + 1'b1;
				CMD_FINISH: begin
					pc_q <= pc_nx_q;
					if (dt_q != 8'd0) dt_q <= dt_q - 1'b1;
					if (st_q != 8'd0) st_q <= st_q - 1'b1;
					if (is_move) i_q <= i_q + {12'd0, fx} + 16'd1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd == CMD_RESULT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_RESULT && out_free) begin
			out_pc_q      <= pc_q;
			out_changed_q <= changed_q;
			out_sound_q   <= (st_q != 8'd0);
			out_wait_q    <= wait_q;
			out_row_q     <= (rq_cmd_q == RQ_ROW && rq_addr_q[AW-1:ROW_AW] == '0) ?
				fr_rd_q : '0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign program_counter = out_pc_q;
	assign display_changed = out_changed_q;
	assign sound_active    = out_sound_q;
	assign waiting_for_key = out_wait_q;
	assign row_pixels      = out_row_q;

endmodule

// ===== rtl/chip8_interpreter_core.sv =====
// From taking a request to its result at the output: memory write, row read and no-op
//   requests pass dispatch and the result state; an instruction is fetched high then low
//   byte, decoded, executed and finished; an 8XYN op that sets VF and a sprite draw also
//   write VF; a draw reads and writes its N rows, BCD writes three digits, a block store or
//   load moves V0 to VX one at a time over the single memory port and register-file port.
// One request in flight; the next is taken once the last result is loaded into the output
//   register, even while it waits to be taken. Reset sweep loads the font and zeroes main memory; stall held high.
module chip8_interpreter_core #(
	parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic [15:0] key_mask,
	input  logic [7:0]  random_byte,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [11:0] program_counter,
	output logic        display_changed,
	output logic        sound_active,
	output logic        waiting_for_key,
	output logic [63:0] row_pixels
);
	import c8_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: walks each request through fetch, decode, execute and the
	// multi-cycle walks (sprite rows, BCD digits, register block moves)
	c8_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.status    (status),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	// datapath: memories, registers, ALU and the output register
	c8_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.command         (command),
		.address         (address),
		.write_data      (write_data),
		.key_mask        (key_mask),
		.random_byte     (random_byte),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.program_counter (program_counter),
		.display_changed (display_changed),
		.sound_active    (sound_active),
		.waiting_for_key (waiting_for_key),
		.row_pixels      (row_pixels)
	);

	// hold off further requests while one is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second request taken while one in flight");

	// fetch always completes both bytes in order
	a_fetch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_FETCH_HI) |=> (cmd == CMD_FETCH_LO))
		else $error("instruction fetch broken");

	// a result loaded into a free output register shows up next cycle
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_RESULT && status.out_free) |=> rsp_valid)
		else $error("result lost");

endmodule
